>>> rtl/core/dfnv_pkg.sv
// ----------------------------------------------------------------------------
// dfnv_pkg: shared types and constants for the device identifier hash core
// Holds the FNV-1a constants, register reset values, register indexes,
// sequencer states and the byte mixing function.
// ----------------------------------------------------------------------------
package dfnv_pkg;

   localparam logic [63:0] FNV_OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;
   // FNV prime is 2^40 + 0x1B3
   localparam logic [8:0]  FNV_PRIME_LOW    = 9'h1B3;
   localparam int unsigned FNV_PRIME_SHIFT  = 40;

   localparam int unsigned MAC_W      = 48;
   localparam int unsigned BASE_W     = 63;
   localparam int unsigned ID_W       = 64;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned MAC_BYTES  = MAC_W / 8;
   localparam int unsigned MAC_CNT_W  = $clog2(MAC_BYTES);
   localparam int unsigned DIV_CNT_W  = $clog2(ID_W);

   localparam logic [BASE_W-1:0] ID_BASE_RESET = 63'd10000000000000000;
   localparam logic [ID_W-1:0]   ID_SPAN_RESET = 64'd170000000000000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAC_ADDRESS = 2'd0,
      CSR_ID_BASE     = 2'd1,
      CSR_ID_SPAN     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_CHAR,
      ST_DIV,
      ST_DONE
   } state_type;

   // XOR the byte in, then multiply by the FNV prime modulo 2^64
   function automatic logic [ID_W-1:0] fnv_mix(input logic [ID_W-1:0] h,
                                                input logic [7:0]      b);
      logic [ID_W-1:0] x;
      x = h ^ {{(ID_W-8){1'b0}}, b};
      return (x << FNV_PRIME_SHIFT) + (x * {{(ID_W-9){1'b0}}, FNV_PRIME_LOW});
   endfunction

endpackage

>>> rtl/core/dfnv_req_if.sv
// ----------------------------------------------------------------------------
// dfnv_req_if: name character channel
// Carries one name character and its last flag per beat.
// ----------------------------------------------------------------------------
interface dfnv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] name_byte;
   logic       last_char;

   modport source (output valid, output name_byte, output last_char, input ready);
   modport sink   (input valid, input name_byte, input last_char, output ready);
endinterface

>>> rtl/core/dfnv_rsp_if.sv
// ----------------------------------------------------------------------------
// dfnv_rsp_if: device identifier channel
// Carries one finished device identifier per beat.
// ----------------------------------------------------------------------------
interface dfnv_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] device_id;

   modport source (output valid, output device_id, input ready);
   modport sink   (input valid, input device_id, output ready);
endinterface

>>> rtl/core/dfnv_csr_if.sv
// ----------------------------------------------------------------------------
// dfnv_csr_if: register write channel
// Carries a register index and its write data per beat.
// ----------------------------------------------------------------------------
interface dfnv_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/device_id_fnv1a_hash_core.sv
// ----------------------------------------------------------------------------
// device_id_fnv1a_hash_core: device identifier from MAC and name (FNV-1a 64)
//
//   channel    dir   payload                    role
//   req_chan   in    name_byte[7:0], last_char  one name character per beat
//   rsp_chan   out   device_id[63:0]            one identifier per finished name
//   csr_chan   in    index[1:0], data[63:0]     register write, always ready
//
// A name's first character is accepted, then six MAC byte mixes and one
// character mix follow, all through one shared mix unit; later characters
// are accepted and mixed alone. A finished name adds a restoring division
// (one quotient bit a cycle) and the base add; zero id_span skips division.
// Reset is synchronous: it clears sequencer and flags, loads register resets.
// A stalled response holds in its output register; the core keeps taking
// characters and only parks at the final step until that register frees.
// ----------------------------------------------------------------------------
module device_id_fnv1a_hash_core
   import dfnv_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   dfnv_req_if.sink  req_chan,
   dfnv_rsp_if.source rsp_chan,
   dfnv_csr_if.sink  csr_chan
);

   // control state
   state_type             state_ff, state_in;
   logic                  in_name_ff, in_name_in;
   logic [MAC_CNT_W-1:0]  mac_cnt_ff, mac_cnt_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // configuration registers
   logic [MAC_W-1:0]      mac_ff;
   logic [BASE_W-1:0]     base_ff;
   logic [ID_W-1:0]       span_ff;

   // datapath registers
   logic [ID_W-1:0]       hash_ff, hash_in;
   logic [ID_W-1:0]       rem_ff, rem_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  last_ff, last_in;
   logic [ID_W-1:0]       rsp_data_ff, rsp_data_in;

   // sequencer outputs
   logic                  req_take;
   logic                  mix_sel_mac;
   logic                  name_end;
   logic                  out_free;
   logic                  fin_load;

   // shared unit signals
   logic [7:0]            mac_byte;
   logic [7:0]            mix_operand;
   logic [ID_W-1:0]       mix_out;
   logic [ID_W-1:0]       char_hash;
   logic [ID_W:0]         div_trial;
   logic [ID_W:0]         div_diff;

   // ---------------------------------------------------------------------
   // Sequencer: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      req_take       = req_chan.valid && (state_ff == ST_IDLE);
      mix_sel_mac    = (state_ff == ST_MAC);
      // a zero character ends the name unmixed; a last flag ends it after mixing
      name_end       = (byte_ff == 8'd0) || last_ff;
      out_free       = !rsp_valid_ff || rsp_chan.ready;
      fin_load       = (state_ff == ST_DONE) && out_free;
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = in_name_ff ? ST_CHAR : ST_MAC;
            end
         end
         ST_MAC: begin
            if (mac_cnt_ff == MAC_CNT_W'(MAC_BYTES - 1)) begin
               state_in = ST_CHAR;
            end
         end
         ST_CHAR: begin
            if (!name_end) begin
               state_in = ST_IDLE;
            end else if (span_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Shared mix unit: MAC bytes during ST_MAC, the held character otherwise
   // ---------------------------------------------------------------------
   assign mac_byte    = 8'(mac_ff >> {mac_cnt_ff, 3'b000});
   assign mix_operand = mix_sel_mac ? mac_byte : byte_ff;
   assign mix_out     = fnv_mix(hash_ff, mix_operand);
   assign char_hash   = (byte_ff == 8'd0) ? hash_ff : mix_out;

   // restoring division step: shift in the next dividend bit, subtract if it fits
   assign div_trial   = {rem_ff, hash_ff[ID_W-1]};
   assign div_diff    = div_trial - {1'b0, span_ff};

   // ---------------------------------------------------------------------
   // Datapath next values
   // ---------------------------------------------------------------------
   always_comb begin
      hash_in      = hash_ff;
      rem_in       = rem_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      in_name_in   = in_name_ff;
      mac_cnt_in   = mac_cnt_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               byte_in = req_chan.name_byte;
               last_in = req_chan.last_char;
               if (!in_name_ff) begin
                  // new name: restart the hash, sample the MAC from here on
                  hash_in    = FNV_OFFSET_BASIS;
                  mac_cnt_in = '0;
                  in_name_in = 1'b1;
               end
            end
         end
         ST_MAC: begin
            hash_in    = mix_out;
            mac_cnt_in = mac_cnt_ff + MAC_CNT_W'(1);
         end
         ST_CHAR: begin
            hash_in    = char_hash;
            // zero span means no reduction: pass the hash through
            rem_in     = (span_ff == '0) ? char_hash : '0;
            div_cnt_in = DIV_CNT_W'(ID_W - 1);
         end
         ST_DIV: begin
            hash_in    = hash_ff << 1;
            rem_in     = div_diff[ID_W] ? div_trial[ID_W-1:0] : div_diff[ID_W-1:0];
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
         end
         ST_DONE: begin
            if (fin_load) begin
               rsp_data_in  = {1'b0, base_ff} + rem_ff;
               rsp_valid_in = 1'b1;
               in_name_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_name_ff   <= 1'b0;
         mac_cnt_ff   <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_name_ff   <= in_name_in;
         mac_cnt_ff   <= mac_cnt_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff     <= hash_in;
      rem_ff      <= rem_in;
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // register writes: keep the low MAC and base bits, ignore unknown indexes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff  <= '0;
         base_ff <= ID_BASE_RESET;
         span_ff <= ID_SPAN_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_MAC_ADDRESS: begin
               mac_ff <= csr_chan.data[MAC_W-1:0];
            end
            CSR_ID_BASE: begin
               base_ff <= csr_chan.data[BASE_W-1:0];
            end
            CSR_ID_SPAN: begin
               span_ff <= csr_chan.data;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.device_id = rsp_data_ff;

endmodule

>>> rtl/core/dfnv_checker.sv
// ----------------------------------------------------------------------------
// dfnv_checker: port-level checks for the device identifier hash core
// Watches the request and response handshakes and is bound to the top level.
// ----------------------------------------------------------------------------
module dfnv_checker
   import dfnv_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [ID_W-1:0] rsp_device_id
);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_device_id))
      else $error("response beat dropped or changed under stall");

   // one character at a time: busy right after a request beat
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous character in flight");

   // an identifier needs at least the mix step before it can appear
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response appeared too soon after request beat");

   // out of reset: idle and nothing pending
   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_ready && !rsp_valid)
      else $error("core not idle after reset");

endmodule

bind device_id_fnv1a_hash_core dfnv_checker u_dfnv_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_device_id (rsp_chan.device_id)
);
